// ===== rtl/sse_pkg.sv =====
// Shared types, codes and constants of the sorted set engine.
package sse_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int VALUE_W      = 32;
	localparam int OPCODE_W     = 2;
	localparam int STATUS_W     = 2;
	localparam int COUNT_W      = 5;

	localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_DONE     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_NOCHANGE = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

	typedef logic signed [VALUE_W-1:0] value_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_UPD,
		ST_RSP
	} state_t;

endpackage

// ===== rtl/sse_if.sv =====
// Valid/ready channel interfaces for requests and responses of the sorted set engine.
interface sse_req_if;
	import sse_pkg::*;

	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	value_t              value;

	modport source (output valid, output opcode, output value, input ready);
	modport sink (input valid, input opcode, input value, output ready);
endinterface

interface sse_rsp_if;
	import sse_pkg::*;

	logic                valid;
	logic                ready;
	logic                found;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	modport source (output valid, output found, output status, output entry_count, input ready);
	modport sink (input valid, input found, input status, input entry_count, output ready);
endinterface

// ===== rtl/sse_cell.sv =====
// One storage cell of the sorted row: holds a key, compares it and shifts with its neighbors.
module sse_cell (
	input  logic               clk,
	input  sse_pkg::cell_cmd_t cmd,
	input  sse_pkg::value_t    key,
	input  logic               active,
	input  logic               left_less,
	input  sse_pkg::value_t    left_value,
	input  sse_pkg::value_t    right_value,
	output sse_pkg::value_t    value,
	output logic               less,
	output logic               eq
);
	import sse_pkg::*;

	value_t value_q;
	logic   less_q;
	logic   eq_q;

	// Only cells below the fill count take part in a compare.
	always_ff @(posedge clk) begin
		if (cmd.cmp) begin
			less_q <= active && (value_q < key);
			eq_q   <= active && (value_q == key);
		end
	end

	// Cells at or above the key position open a gap on insert and close it on delete.
	always_ff @(posedge clk) begin
		if (cmd.ins && !less_q) begin
			value_q <= left_less ? key : left_value;
		end else if (cmd.del && !less_q) begin
			value_q <= right_value;
		end
	end

	assign value = value_q;
	assign less  = less_q;
	assign eq    = eq_q;

endmodule

// ===== rtl/sorted_set_engine_top.sv =====
// Top level of the sorted set engine: request control and the row of storage cells.
//
// The engine keeps a set of distinct signed 32-bit keys in ascending order in a row
// of CAPACITY cells. Requests arrive on the req channel (opcode, value) and each one
// yields exactly one response item on the rsp channel (found, status, entry_count).
// Opcode 0 searches, 1 inserts, 2 deletes; the unused code 3 behaves as a search.
// An insert of a key already present reports no change, and an insert into a full
// set is rejected with the full status.
// The request is latched at the edge that accepts it. In the compare state every cell
// compares its key against the broadcast value, in the update state the row shifts
// right (insert) or left (delete) around the key position and the response is
// registered, and in the response state the response is valid. The compare-then-shift
// sequence through the cell row sets the pace: one item is in flight at a time, and
// a new request is accepted only once the previous response has been taken.
// The response stays valid and unchanged while the receiver holds ready low, and no
// new request is accepted until it is taken.
// Reset empties the set and the control; cell contents are not cleared, since only
// cells below the fill count are ever looked at.
module sorted_set_engine_top #(
	parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sse_req_if.sink   req,
	sse_rsp_if.source rsp
);
	import sse_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t                state_q;
	state_t                state_d;
	logic [OPCODE_W-1:0]   op_q;
	value_t                key_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;
	logic                  found_q;
	logic                  found_d;
	logic [STATUS_W-1:0]   status_q;
	logic [STATUS_W-1:0]   status_d;
	cell_cmd_t             cmd;
	logic                  hit;
	logic                  full;
	logic [31:0]           count_ext;

	value_t                cell_val  [CAPACITY];
	logic [CAPACITY-1:0]   cell_less;
	logic [CAPACITY-1:0]   cell_eq;

	// The row of cells. Each cell sees the less flag and key of its left neighbor
	// and the key of its right neighbor.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CNT_W-1:0] CELL_IDX = CNT_W'(i);
		logic   left_less;
		value_t left_value;
		value_t right_value;

		if (i == 0) begin : g_first
			assign left_less  = 1'b1;
			assign left_value = key_q;
		end else begin : g_mid
			assign left_less  = cell_less[i-1];
			assign left_value = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_value = cell_val[i];
		end else begin : g_inner
			assign right_value = cell_val[i+1];
		end

		sse_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.key         (key_q),
			.active      (CELL_IDX < count_q),
			.left_less   (left_less),
			.left_value  (left_value),
			.right_value (right_value),
			.value       (cell_val[i]),
			.less        (cell_less[i]),
			.eq          (cell_eq[i])
		);
	end

	assign hit  = |cell_eq;
	assign full = (count_q == CNT_W'(CAPACITY));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q  <= req.opcode;
			key_q <= req.value;
		end
		if (state_q == ST_UPD) begin
			found_q  <= found_d;
			status_q <= status_d;
		end
	end

	// Next state, cell commands and the response of the current item.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		cmd      = '0;
		found_d  = hit;
		status_d = hit ? STAT_DONE : STAT_NOCHANGE;

		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = ST_RSP;
				priority if (op_q == OP_INSERT) begin
					priority if (hit) begin
						status_d = STAT_NOCHANGE;
					end else if (full) begin
						status_d = STAT_FULL;
					end else begin
						cmd.ins  = 1'b1;
						count_d  = count_q + CNT_W'(1);
						status_d = STAT_DONE;
					end
				end else if (op_q == OP_DELETE) begin
					if (hit) begin
						cmd.del  = 1'b1;
						count_d  = count_q - CNT_W'(1);
						status_d = STAT_DONE;
					end else begin
						status_d = STAT_NOCHANGE;
					end
				end else begin
					status_d = hit ? STAT_DONE : STAT_NOCHANGE;
				end
			end
			ST_RSP: begin
				if (rsp.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The reported count wraps to the width of the response field.
	assign count_ext = 32'(count_q);

	assign req.ready       = (state_q == ST_IDLE);
	assign rsp.valid       = (state_q == ST_RSP);
	assign rsp.found       = found_q;
	assign rsp.status      = status_q;
	assign rsp.entry_count = count_ext[COUNT_W-1:0];

endmodule

// ===== verif/sse_set_checker.sv =====
// Response checker for the sorted set engine: keeps its own copy of the key set and compares.
`timescale 1ns / 100ps
module sse_set_checker #(
	parameter int CAPACITY = sse_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	sse_req_if          req,
	sse_rsp_if          rsp,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	import sse_pkg::*;

	typedef struct packed {
		logic                found;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  entry_count;
	} set_result_t;

	value_t      set_keys [CAPACITY];
	int          set_size;
	set_result_t expected_rsp_q [$];
	int unsigned fail_total;

	// Applies one operation to the shadow set and returns the response it must produce.
	function automatic set_result_t apply_set_op(input logic [OPCODE_W-1:0] opcode,
	                                             input value_t key);
		int          pos;
		logic        hit;
		set_result_t res;
		pos = 0;
		while (pos < set_size && set_keys[pos] < key)
			pos++;
		hit = (pos < set_size) && (set_keys[pos] == key);
		res.found = hit;
		case (opcode)
			OP_INSERT: begin
				if (hit) begin
					res.status = STAT_NOCHANGE;
				end else if (set_size >= CAPACITY) begin
					res.status = STAT_FULL;
				end else begin
					for (int i = set_size; i > pos; i--)
						set_keys[i] = set_keys[i-1];
					set_keys[pos] = key;
					set_size++;
					res.status = STAT_DONE;
				end
			end
			OP_DELETE: begin
				if (hit) begin
					for (int i = pos; i + 1 < set_size; i++)
						set_keys[i] = set_keys[i+1];
					set_size--;
					res.status = STAT_DONE;
				end else begin
					res.status = STAT_NOCHANGE;
				end
			end
			default: begin
				// Search, and the spare code, which acts as a search.
				res.status = hit ? STAT_DONE : STAT_NOCHANGE;
			end
		endcase
		res.entry_count = set_size[COUNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		set_result_t exp_rsp;
		set_result_t got_rsp;
		if (!arst_n) begin
			set_size = 0;
			expected_rsp_q.delete();
			fail_total = 0;
			fail_count  <= 0;
			outstanding <= 0;
		end else begin
			if (req.valid && req.ready)
				expected_rsp_q.push_back(apply_set_op(req.opcode, req.value));
			if (rsp.valid && rsp.ready) begin
				got_rsp.found       = rsp.found;
				got_rsp.status      = rsp.status;
				got_rsp.entry_count = rsp.entry_count;
				if (expected_rsp_q.size() == 0) begin
					fail_total++;
					if (fail_total <= 10)
						$display("%0t: unexpected item: found=%0b status=%0d count=%0d",
						         $realtime, got_rsp.found, got_rsp.status,
						         got_rsp.entry_count);
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (got_rsp.found !== exp_rsp.found || got_rsp.status !== exp_rsp.status ||
					    got_rsp.entry_count !== exp_rsp.entry_count) begin
						fail_total++;
						if (fail_total <= 10)
							$display("%0t: expected f=%0b s=%0d n=%0d, got f=%0b s=%0d n=%0d",
							         $realtime, exp_rsp.found, exp_rsp.status,
							         exp_rsp.entry_count, got_rsp.found,
							         got_rsp.status, got_rsp.entry_count);
					end
				end
			end
			fail_count  <= fail_total;
			outstanding <= expected_rsp_q.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
// Top of the sorted set engine testbench: clock, reset, request stimulus and response stalls.
`timescale 1ns / 100ps
module testbench;
	import sse_pkg::*;

	// The spare opcode has no name in the package; the engine treats it as a search.
	localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

	localparam value_t KEY_MIN = 32'sh8000_0000;
	localparam value_t KEY_MAX = 32'sh7FFF_FFFF;

	// The random part is cut into segments, each with its own mix of operations.
	localparam int RANDOM_ITEMS = 1350;
	localparam int SEGMENT_LEN  = 150;
	localparam int QUIET_TAIL   = 150;
	localparam int POOL_N       = 24;
	localparam int HOLD_CYCLES  = 250;

	typedef enum logic [1:0] {
		MIX_OPS,
		FILL_OPS,
		DRAIN_OPS
	} op_mix_t;

	logic        clk;
	logic        arst_n;
	int unsigned fail_count;
	int unsigned outstanding;

	// Shared between the sender and the receiver process.
	bit idle_on;
	bit hold_request;

	// The pool holds more keys than the engine can store, so that fill-heavy segments
	// reach the full state while deletes and searches still hit often.
	value_t key_pool [POOL_N];

	sse_req_if req_ch ();
	sse_rsp_if rsp_ch ();

	sorted_set_engine_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	sse_set_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the engine hangs. The slowest correct run is far below this.
	initial begin
		#3_000_000;
		$display("sorted_set_engine_top: mismatch");
		$finish;
	end

	// Offers one item and returns once it has been taken. Valid stays high afterwards
	// unless an idle burst follows, so back-to-back items keep valid asserted.
	task automatic send_item(input logic [OPCODE_W-1:0] opcode, input value_t key);
		req_ch.valid  <= 1'b1;
		req_ch.opcode <= opcode;
		req_ch.value  <= key;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 17))
				@(posedge clk);
		end
	endtask

	// Most keys come from the pool so that hits are common. The rest are raw random
	// words, which also make every value bit toggle, and the two extremes.
	function automatic value_t pick_key();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return key_pool[$urandom_range(0, POOL_N-1)];
		if (roll < 92)
			return value_t'($urandom);
		return roll[0] ? KEY_MAX : KEY_MIN;
	endfunction

	function automatic logic [OPCODE_W-1:0] pick_opcode(input op_mix_t mix);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		case (mix)
			FILL_OPS: begin
				if (roll < 65) return OP_INSERT;
				if (roll < 80) return OP_SEARCH;
				if (roll < 95) return OP_DELETE;
			end
			DRAIN_OPS: begin
				if (roll < 65) return OP_DELETE;
				if (roll < 80) return OP_SEARCH;
				if (roll < 95) return OP_INSERT;
			end
			default: begin
				if (roll < 30) return OP_SEARCH;
				if (roll < 62) return OP_INSERT;
				if (roll < 95) return OP_DELETE;
			end
		endcase
		return OP_SPARE;
	endfunction

	// Receiver: ready drops in random bursts while idling is on. Once, on request of
	// the sender, it holds off for a long counted stretch so the engine backs up and
	// stops taking requests while the sender keeps offering.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(1, 17) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus: a directed walk through the special cases, then the random segments.
	initial begin
		int      segment;
		op_mix_t mix;
		arst_n        = 1'b0;
		idle_on       = 1'b1;
		hold_request  = 1'b0;
		req_ch.valid  <= 1'b0;
		req_ch.opcode <= OP_SEARCH;
		req_ch.value  <= '0;

		key_pool[0] = KEY_MIN;
		key_pool[1] = KEY_MAX;
		key_pool[2] = 0;
		key_pool[3] = -1;
		key_pool[4] = 1;
		for (int i = 5; i < POOL_N; i++)
			key_pool[i] = i[0] ? value_t'($urandom) : value_t'($urandom_range(0, 200)) - 100;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Operations on the empty set.
		send_item(OP_SEARCH, 5);
		send_item(OP_DELETE, 5);
		// Build a small set around both extremes, then try a duplicate insert.
		send_item(OP_INSERT, KEY_MIN);
		send_item(OP_INSERT, KEY_MAX);
		send_item(OP_INSERT, 0);
		send_item(OP_INSERT, -1);
		send_item(OP_INSERT, 1);
		send_item(OP_INSERT, KEY_MAX);
		// Searches that hit and miss, including the spare opcode both ways.
		send_item(OP_SEARCH, KEY_MIN);
		send_item(OP_SEARCH, 7);
		send_item(OP_SPARE, 0);
		send_item(OP_SPARE, 7);
		// Delete from the middle, the top and the bottom, then an absent key.
		send_item(OP_DELETE, 0);
		send_item(OP_DELETE, KEY_MAX);
		send_item(OP_DELETE, KEY_MIN);
		send_item(OP_DELETE, 42);
		send_item(OP_DELETE, -1);
		// Deleting the only element must leave the set empty.
		send_item(OP_DELETE, 1);
		send_item(OP_SEARCH, 1);
		send_item(OP_DELETE, 1);

		// Fill, mix and drain segments alternate, so the set runs from empty to full
		// and back several times. Full-set inserts and duplicates at full come from here.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			segment = n / SEGMENT_LEN;
			case (segment % 3)
				0:       mix = FILL_OPS;
				1:       mix = MIX_OPS;
				default: mix = DRAIN_OPS;
			endcase
			idle_on = (n < RANDOM_ITEMS - QUIET_TAIL) && (segment % 4 != 2);
			if (n == 500)
				hold_request = 1'b1;
			send_item(pick_opcode(mix), pick_key());
		end
		req_ch.valid <= 1'b0;

		// The last item was counted by the checker at its accepting edge; step past it
		// before looking at what is still outstanding.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (fail_count == 0 && outstanding == 0)
			$display("sorted_set_engine_top: match");
		else
			$display("sorted_set_engine_top: mismatch");
		$finish;
	end

endmodule
